[rtl/input_dpm_voltage_band_selector_top_defines.svh]
`ifndef INPUT_DPM_VOLTAGE_BAND_SELECTOR_TOP_DEFINES_SVH
`define INPUT_DPM_VOLTAGE_BAND_SELECTOR_TOP_DEFINES_SVH

// Same-cycle implication, masked while rst is high.
`define IDPM_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("idpm: same-cycle check failed");

// Next-cycle implication, masked while rst is high.
`define IDPM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("idpm: next-cycle check failed");

`endif

[rtl/idpm_vbs_pkg.sv]
package idpm_vbs_pkg;

   localparam int unsigned BAT_W     = 15;
   localparam int unsigned BUS_W     = 14;
   localparam int unsigned CLS_W     = 2;
   localparam int unsigned DPM_W     = 13;
   localparam int unsigned LVL_W     = 3;
   localparam int unsigned BOUND_W   = 16;
   localparam int unsigned BACK_W    = 4;
   localparam int unsigned WORD_W    = 49;
   localparam int unsigned CSR_IDX_W = 3;
   // signed headroom between a bound and the battery voltage
   localparam int unsigned CMP_W     = 18;

   // request kinds
   localparam logic KIND_SAMPLE  = 1'b0;
   localparam logic KIND_RESTART = 1'b1;

   // charger classes (code 3 behaves as a standard adapter)
   localparam logic [CLS_W-1:0] CLS_STANDARD = 2'd0;
   localparam logic [CLS_W-1:0] CLS_FAST     = 2'd1;
   localparam logic [CLS_W-1:0] CLS_HOST     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_TABLE_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALT_BUCK     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEVEL_BASE   = 3'd2;

   localparam logic [BUS_W-1:0] BUS_FAST_MIN_MV = 14'd6500;
   localparam logic [DPM_W-1:0] BASE_MV         = 13'd4600;
   localparam logic [DPM_W-1:0] BASE_ALT_MV     = 13'd4625;
   localparam logic [DPM_W-1:0] FAST_DPM_MV     = 13'd8100;

   typedef struct packed {
      logic              kind;
      logic [BAT_W-1:0]  battery_mv;
      logic [BUS_W-1:0]  bus_mv;
      logic [CLS_W-1:0]  chg_class;
   } req_type;

   typedef struct packed {
      logic [DPM_W-1:0]  dpm_mv;
      logic              from_table;
      logic [LVL_W-1:0]  matched_level;
   } rsp_type;

   typedef struct packed {
      logic [LVL_W-1:0]  prev_level;
      logic [DPM_W-1:0]  prev_dpm;
      logic [BAT_W-1:0]  prev_battery;
      logic              first_pass;
   } state_type;

   // layout of one level word, MSB first
   typedef struct packed {
      logic [BACK_W-1:0]         backoff;
      logic [DPM_W-1:0]          dpm;
      logic signed [BOUND_W-1:0] high;
      logic signed [BOUND_W-1:0] low;
   } level_type;

endpackage

[rtl/idpm_vbs_ifs.sv]
interface idpm_vbs_req_if
   import idpm_vbs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic              kind;
   logic [BAT_W-1:0]  battery_mv;
   logic [BUS_W-1:0]  bus_mv;
   logic [CLS_W-1:0]  chg_class;

   modport source (output valid, kind, battery_mv, bus_mv, chg_class, input ready);
   modport sink (input valid, kind, battery_mv, bus_mv, chg_class, output ready);
endinterface

interface idpm_vbs_rsp_if
   import idpm_vbs_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DPM_W-1:0]  dpm_mv;
   logic              from_table;
   logic [LVL_W-1:0]  matched_level;

   modport source (output valid, dpm_mv, from_table, matched_level, input ready);
   modport sink (input valid, dpm_mv, from_table, matched_level, output ready);
endinterface

interface idpm_vbs_csr_if
   import idpm_vbs_pkg::*;
   ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [WORD_W-1:0]     wdata;

   modport source (output valid, index, wdata, input ready);
   modport sink (input valid, index, wdata, output ready);
endinterface

[rtl/idpm_vbs_core.sv]
module idpm_vbs_core
   import idpm_vbs_pkg::*;
   #(parameter int unsigned LEVELS = 5)
   (
   input  req_type           item,
   input  logic              table_enable,
   input  logic              alt_buck_mode,
   input  logic [WORD_W-1:0] level_word [LEVELS],
   input  state_type         state_cur,
   output logic              emit,
   output rsp_type           result,
   output state_type         state_nxt
   );

   logic [LEVELS-1:0] hit;
   logic [LEVELS-1:0] take;
   logic [DPM_W-1:0]  level_dpm [LEVELS];
   logic              sel_hit;
   logic              sel_take;
   logic [DPM_W-1:0]  sel_dpm;
   logic [LVL_W-1:0]  sel_level;

   // band compares, one per level, all in parallel
   always_comb begin
      level_type          lvl;
      logic signed [CMP_W-1:0] vbat_s;
      logic signed [CMP_W-1:0] lo_s;
      logic signed [CMP_W-1:0] hi_s;
      logic signed [CMP_W-1:0] back_s;
      logic signed [CMP_W-1:0] headroom;
      logic [LVL_W:0]     pl;
      logic [LVL_W:0]     idx;
      logic               fell;
      logic               far;
      vbat_s = signed'(CMP_W'(item.battery_mv));
      pl     = (LVL_W+1)'(state_cur.prev_level);
      fell   = state_cur.prev_battery > item.battery_mv;
      for (int i = 0; i < LEVELS; i++) begin
         lvl          = level_type'(level_word[i]);
         lo_s         = CMP_W'(lvl.low);
         hi_s         = CMP_W'(lvl.high);
         back_s       = signed'(CMP_W'(lvl.backoff));
         headroom     = hi_s - vbat_s;
         idx          = (LVL_W+1)'(i);
         far          = (pl > idx + 1'b1) || (idx > pl + 1'b1);
         hit[i]       = (vbat_s >= lo_s) && (vbat_s < hi_s);
         take[i]      = (headroom > back_s) || (!fell && pl <= idx) || far
                        || state_cur.first_pass;
         level_dpm[i] = lvl.dpm;
      end
   end

   // lowest matching index wins
   always_comb begin
      sel_hit   = 1'b0;
      sel_take  = 1'b0;
      sel_dpm   = '0;
      sel_level = '0;
      for (int i = LEVELS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            sel_hit   = 1'b1;
            sel_take  = take[i];
            sel_dpm   = level_dpm[i];
            sel_level = LVL_W'(i);
         end
      end
   end

   always_comb begin
      logic [DPM_W-1:0] base;
      base      = alt_buck_mode ? BASE_ALT_MV : BASE_MV;
      emit      = 1'b1;
      result    = '{dpm_mv: base, from_table: 1'b0, matched_level: '0};
      state_nxt = state_cur;
      if (item.kind == KIND_RESTART) begin
         emit                 = 1'b0;
         state_nxt.first_pass = 1'b1;
      end else if (item.chg_class == CLS_FAST && item.bus_mv >= BUS_FAST_MIN_MV) begin
         result.dpm_mv = FAST_DPM_MV;
      end else if (item.chg_class != CLS_FAST
                   && (!table_enable || item.chg_class == CLS_HOST)) begin
         result.dpm_mv = base;
      end else begin
         if (sel_hit) begin
            result.from_table    = 1'b1;
            result.matched_level = sel_level;
            if (sel_take) begin
               result.dpm_mv        = sel_dpm;
               state_nxt.prev_level = sel_level;
            end else begin
               result.dpm_mv = state_cur.prev_dpm;
            end
         end
         state_nxt.first_pass   = 1'b0;
         state_nxt.prev_battery = item.battery_mv;
         state_nxt.prev_dpm     = result.dpm_mv;
      end
   end

endmodule

[rtl/input_dpm_voltage_band_selector_top.sv]
// An accepted req beat is held in the input register, and its result in the result register, before its rsp beat.
// Throughput: one beat per cycle while rsp ready is high; the band compares and hysteresis sit in one stage.
// Restart beats produce no rsp beat and leave the input register without waiting for rsp ready.
// Reset (synchronous, active high) empties both registers, zeroes the configuration,
// clears the hysteresis history and sets the first-pass flag.
module input_dpm_voltage_band_selector_top
   import idpm_vbs_pkg::*;
   #(parameter int unsigned LEVELS = 5)
   (
   input  logic            clock,
   input  logic            reset,
   idpm_vbs_req_if.sink    req_chan,
   idpm_vbs_rsp_if.source  rsp_chan,
   idpm_vbs_csr_if.sink    csr_chan
   );

   logic              table_enable_ff, table_enable_in;
   logic              alt_buck_ff, alt_buck_in;
   logic [WORD_W-1:0] level_word_ff [LEVELS];
   logic [WORD_W-1:0] level_word_in [LEVELS];
   state_type         state_ff, state_in;
   logic              s1_valid_ff, s1_valid_in;
   req_type           s1_item_ff, s1_item_in;
   logic              out_valid_ff, out_valid_in;
   rsp_type           out_rsp_ff, out_rsp_in;

   logic              core_emit;
   rsp_type           core_result;
   state_type         core_state_nxt;
   logic              s1_go;
   logic              req_beat;
   logic              csr_beat;

   idpm_vbs_core #(.LEVELS(LEVELS)) u_core (
      .item          (s1_item_ff),
      .table_enable  (table_enable_ff),
      .alt_buck_mode (alt_buck_ff),
      .level_word    (level_word_ff),
      .state_cur     (state_ff),
      .emit          (core_emit),
      .result        (core_result),
      .state_nxt     (core_state_nxt)
   );

   // advance stage 1 when its result has somewhere to go
   assign s1_go    = s1_valid_ff && (!core_emit || !out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_go;
   assign req_beat = req_chan.valid && req_chan.ready;
   assign csr_chan.ready = 1'b1;
   assign csr_beat = csr_chan.valid;

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.dpm_mv        = out_rsp_ff.dpm_mv;
   assign rsp_chan.from_table    = out_rsp_ff.from_table;
   assign rsp_chan.matched_level = out_rsp_ff.matched_level;

   always_comb begin
      table_enable_in = table_enable_ff;
      alt_buck_in     = alt_buck_ff;
      level_word_in   = level_word_ff;
      if (csr_beat) begin
         if (csr_chan.index == REG_TABLE_ENABLE) begin
            table_enable_in = csr_chan.wdata[0];
         end
         if (csr_chan.index == REG_ALT_BUCK) begin
            alt_buck_in = csr_chan.wdata[0];
         end
         for (int i = 0; i < LEVELS; i++) begin
            if (csr_chan.index == REG_LEVEL_BASE + CSR_IDX_W'(i)) begin
               level_word_in[i] = csr_chan.wdata;
            end
         end
      end
   end

   always_comb begin
      s1_valid_in  = (s1_valid_ff && !s1_go) || req_beat;
      s1_item_in   = req_beat ? req_type'{kind: req_chan.kind,
                                          battery_mv: req_chan.battery_mv,
                                          bus_mv: req_chan.bus_mv,
                                          chg_class: req_chan.chg_class}
                              : s1_item_ff;
      state_in     = s1_go ? core_state_nxt : state_ff;
      out_valid_in = (s1_go && core_emit) || (out_valid_ff && !rsp_chan.ready);
      out_rsp_in   = (s1_go && core_emit) ? core_result : out_rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_enable_ff <= 1'b0;
         alt_buck_ff     <= 1'b0;
         for (int i = 0; i < LEVELS; i++) begin
            level_word_ff[i] <= '0;
         end
         state_ff     <= '{prev_level: '0, prev_dpm: '0, prev_battery: '0, first_pass: 1'b1};
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         table_enable_ff <= table_enable_in;
         alt_buck_ff     <= alt_buck_in;
         level_word_ff   <= level_word_in;
         state_ff        <= state_in;
         s1_valid_ff     <= s1_valid_in;
         out_valid_ff    <= out_valid_in;
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      s1_item_ff <= s1_item_in;
      out_rsp_ff <= out_rsp_in;
   end

endmodule

[rtl/idpm_vbs_checker.sv]
`include "input_dpm_voltage_band_selector_top_defines.svh"

module idpm_vbs_checker
   import idpm_vbs_pkg::*;
   (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic [DPM_W-1:0] rsp_dpm_mv,
   input logic             rsp_from_table,
   input logic [LVL_W-1:0] rsp_matched_level
   );

   logic no_match;
   logic fixed_dpm;

   assign no_match  = rsp_valid && !rsp_from_table;
   assign fixed_dpm = (rsp_dpm_mv == FAST_DPM_MV) || (rsp_dpm_mv == BASE_MV)
                      || (rsp_dpm_mv == BASE_ALT_MV);

   // hold a stalled beat
   `IDPM_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)
   // no table match means level zero
   `IDPM_ASSERT_IMPLY(a_level_zero, clock, reset, no_match, rsp_matched_level == '0)
   // without a table match the answer is one of the fixed values
   `IDPM_ASSERT_IMPLY(a_fixed_value, clock, reset, no_match, fixed_dpm)
   // drop any pending beat on reset
   `IDPM_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid)

endmodule

bind input_dpm_voltage_band_selector_top idpm_vbs_checker u_idpm_vbs_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_dpm_mv        (rsp_chan.dpm_mv),
   .rsp_from_table    (rsp_chan.from_table),
   .rsp_matched_level (rsp_chan.matched_level)
);

[tb/tb_top.sv]
module tb_top;
   import idpm_vbs_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LEVELS          = 5;
   localparam int BLOCKS          = 6;
   localparam int ITEMS_PER_BLOCK = 170;
   localparam int SETTLE_CYCLES   = 8;
   localparam int CYCLE_LIMIT     = 200000;
   localparam int MAX_PRINTED     = 50;

   localparam logic [CLS_W-1:0]     CLS_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED = REG_LEVEL_BASE + CSR_IDX_W'(LEVELS);

   // Predicts the DPM answer of each sample and checks the result beats in order.
   class dpm_scoreboard;
      logic                 table_en;
      logic                 alt_buck;
      level_type            levels[LEVELS];
      logic [LVL_W-1:0]     last_level;
      logic [DPM_W-1:0]     last_dpm;
      logic [BAT_W-1:0]     last_battery;
      logic                 fresh;
      rsp_type              dpm_queue[$];
      int                   errors;
      int                   samples;
      int                   restarts;
      int                   table_hits;
      int                   held_values;

      function new();
         table_en     = 1'b0;
         alt_buck     = 1'b0;
         foreach (levels[i]) levels[i] = '0;
         last_level   = '0;
         last_dpm     = '0;
         last_battery = '0;
         fresh        = 1'b1;
         errors       = 0;
         samples      = 0;
         restarts     = 0;
         table_hits   = 0;
         held_values  = 0;
      endfunction

      function int pending();
         return dpm_queue.size();
      endfunction

      function void write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
         if (idx == REG_TABLE_ENABLE)
            table_en = data[0];
         else if (idx == REG_ALT_BUCK)
            alt_buck = data[0];
         else if (idx >= REG_LEVEL_BASE && idx < REG_UNUSED)
            levels[idx - REG_LEVEL_BASE] = level_type'(data);
      endfunction

      function void note_request(req_type item);
         rsp_type want;
         int      vbat, lo, hi, step;
         logic    take;
         if (item.kind == KIND_RESTART) begin
            fresh = 1'b1;
            restarts++;
            return;
         end
         samples++;
         want.dpm_mv        = alt_buck ? BASE_ALT_MV : BASE_MV;
         want.from_table    = 1'b0;
         want.matched_level = '0;
         if (item.chg_class == CLS_FAST && item.bus_mv >= BUS_FAST_MIN_MV) begin
            want.dpm_mv = FAST_DPM_MV;
            dpm_queue.push_back(want);
            return;
         end
         if (item.chg_class != CLS_FAST && (!table_en || item.chg_class == CLS_HOST)) begin
            dpm_queue.push_back(want);
            return;
         end
         // table pass: first level whose band holds the battery voltage
         vbat = int'(item.battery_mv);
         for (int i = 0; i < LEVELS; i++) begin
            lo = int'($signed(levels[i].low));
            hi = int'($signed(levels[i].high));
            if (vbat >= lo && vbat < hi) begin
               step = int'(last_level) - i;
               if (step < 0) step = -step;
               take = ((hi - vbat) > int'(levels[i].backoff))
                  || ((int'(last_battery) - vbat) <= 0 && int'(last_level) <= i)
                  || step > 1
                  || fresh;
               if (take) begin
                  want.dpm_mv = levels[i].dpm;
                  last_level  = LVL_W'(i);
               end else begin
                  want.dpm_mv = last_dpm;
                  held_values++;
               end
               want.from_table    = 1'b1;
               want.matched_level = LVL_W'(i);
               table_hits++;
               break;
            end
         end
         fresh        = 1'b0;
         last_battery = item.battery_mv;
         last_dpm     = want.dpm_mv;
         dpm_queue.push_back(want);
      endfunction

      task report(string msg);
         errors++;
         if (errors <= MAX_PRINTED) $display("mismatch: %s", msg);
      endtask

      task check_rsp(rsp_type got);
         rsp_type want;
         if (dpm_queue.size() == 0) begin
            report($sformatf("result with nothing pending, dpm_mv=%0d", got.dpm_mv));
            return;
         end
         want = dpm_queue.pop_front();
         if (got.dpm_mv !== want.dpm_mv)
            report($sformatf("dpm_mv %0d, want %0d", got.dpm_mv, want.dpm_mv));
         if (got.from_table !== want.from_table)
            report($sformatf("from_table %0b, want %0b", got.from_table, want.from_table));
         if (got.matched_level !== want.matched_level)
            report($sformatf("matched_level %0d, want %0d", got.matched_level,
                             want.matched_level));
      endtask

      task finish_check();
         if (dpm_queue.size() != 0)
            report($sformatf("%0d results never arrived", dpm_queue.size()));
      endtask
   endclass

   logic clock;
   logic reset;

   idpm_vbs_req_if req_if();
   idpm_vbs_rsp_if rsp_if();
   idpm_vbs_csr_if csr_if();

   input_dpm_voltage_band_selector_top #(.LEVELS(LEVELS)) u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   dpm_scoreboard     sb = new();
   int                tx_idle_pct;
   int                rx_idle_pct;
   int                cycle_count;
   int                cfg_count;
   int                walk_mv;
   int                band_cut[LEVELS+1];
   logic [WORD_W-1:0] cfg_words[LEVELS];

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("run timed out after %0d cycles", cycle_count);
      $display("CHECK FAILED");
      $finish;
   end

   // receiver: drop ready at random
   initial begin
      rsp_if.ready <= 1'b0;
      forever begin
         @(posedge clock);
         rsp_if.ready <= !reset && ($urandom_range(99) >= rx_idle_pct);
      end
   end

   always @(posedge clock) begin : beat_monitor
      req_type item;
      rsp_type got;
      if (!reset) begin
         if (csr_if.valid && csr_if.ready)
            sb.write_reg(csr_if.index, csr_if.wdata);
         if (rsp_if.valid && rsp_if.ready) begin
            got.dpm_mv        = rsp_if.dpm_mv;
            got.from_table    = rsp_if.from_table;
            got.matched_level = rsp_if.matched_level;
            sb.check_rsp(got);
         end
         if (req_if.valid && req_if.ready) begin
            item.kind       = req_if.kind;
            item.battery_mv = req_if.battery_mv;
            item.bus_mv     = req_if.bus_mv;
            item.chg_class  = req_if.chg_class;
            sb.note_request(item);
         end
      end
   end

   task automatic send_item(req_type item);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid      <= 1'b1;
      req_if.kind       <= item.kind;
      req_if.battery_mv <= item.battery_mv;
      req_if.bus_mv     <= item.bus_mv;
      req_if.chg_class  <= item.chg_class;
      do @(posedge clock); while (!req_if.ready);
   endtask

   task automatic sample(int mv, int bus, logic [CLS_W-1:0] cls);
      req_type item;
      item.kind       = KIND_SAMPLE;
      item.battery_mv = BAT_W'(mv);
      item.bus_mv     = BUS_W'(bus);
      item.chg_class  = cls;
      send_item(item);
   endtask

   // hold off until every pending result has come and the pipe is empty
   task automatic drain();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_IDX_W-1:0] idx, logic [WORD_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.wdata <= data;
      do @(posedge clock); while (!csr_if.ready);
   endtask

   task automatic apply_config(logic te, logic alt);
      drain();
      write_reg(REG_TABLE_ENABLE, WORD_W'(te));
      write_reg(REG_ALT_BUCK, WORD_W'(alt));
      for (int i = 0; i < LEVELS; i++)
         write_reg(REG_LEVEL_BASE + CSR_IDX_W'(i), cfg_words[i]);
      // index past the level list must be ignored
      write_reg(REG_UNUSED, WORD_W'({$urandom(), $urandom()}));
      csr_if.valid <= 1'b0;
      cfg_count++;
   endtask

   function automatic logic [WORD_W-1:0] make_level(int lo, int hi, int dpm, int back);
      level_type lw;
      lw.low     = BOUND_W'(lo);
      lw.high    = BOUND_W'(hi);
      lw.dpm     = DPM_W'(dpm);
      lw.backoff = BACK_W'(back);
      return lw;
   endfunction

   // ascending bands, now and then overlapping, empty or starting below zero
   task automatic make_band_table();
      int lo;
      band_cut[0] = $urandom_range(0, 4000);
      for (int i = 0; i < LEVELS; i++)
         band_cut[i+1] = band_cut[i] + $urandom_range(0, 700);
      if ($urandom_range(3) == 0) band_cut[LEVELS] = 32767;
      for (int i = 0; i < LEVELS; i++) begin
         lo = band_cut[i];
         if (i == 0 && $urandom_range(2) == 0)
            lo = -$urandom_range(1, 32768);
         else if (i > 0 && $urandom_range(3) == 0)
            lo = lo - $urandom_range(1, 200);
         cfg_words[i] = make_level(lo, band_cut[i+1], $urandom_range(0, 8191),
                                   $urandom_range(0, 15));
      end
   endtask

   function automatic int pick_battery();
      int r, v;
      r = $urandom_range(99);
      if (r < 30)
         v = $urandom_range(0, 32767);
      else if (r < 55)
         v = band_cut[$urandom_range(0, LEVELS)] + $urandom_range(0, 40) - 20;
      else
         v = walk_mv + $urandom_range(0, 60) - 30;
      if (v < 0) v = 0;
      if (v > 32767) v = 32767;
      walk_mv = v;
      return v;
   endfunction

   task automatic send_random_item();
      req_type item;
      int      r;
      item.kind       = ($urandom_range(99) < 5) ? KIND_RESTART : KIND_SAMPLE;
      item.battery_mv = BAT_W'(pick_battery());
      r = $urandom_range(99);
      if (r < 40)
         item.bus_mv = BUS_W'($urandom_range(0, 6499));
      else if (r < 50)
         item.bus_mv = BUS_W'(6499 + $urandom_range(0, 1));
      else
         item.bus_mv = BUS_W'($urandom_range(0, 16383));
      r = $urandom_range(99);
      if (r < 45)
         item.chg_class = CLS_STANDARD;
      else if (r < 55)
         item.chg_class = CLS_UNUSED;
      else if (r < 85)
         item.chg_class = CLS_FAST;
      else
         item.chg_class = CLS_HOST;
      send_item(item);
   endtask

   initial begin
      req_type item;
      reset             <= 1'b1;
      req_if.valid      <= 1'b0;
      req_if.kind       <= KIND_SAMPLE;
      req_if.battery_mv <= '0;
      req_if.bus_mv     <= '0;
      req_if.chg_class  <= CLS_STANDARD;
      csr_if.valid      <= 1'b0;
      csr_if.index      <= REG_TABLE_ENABLE;
      csr_if.wdata      <= '0;
      tx_idle_pct = 17;
      rx_idle_pct = 69;
      cfg_count   = 0;
      walk_mv     = 3000;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: table off, all levels zero
      sample(3000, 100, CLS_FAST);
      sample(3000, 100, CLS_STANDARD);

      cfg_words[0] = make_level(1000, 3000, 4400, 15);
      cfg_words[1] = make_level(3000, 3500, 4500, 10);
      cfg_words[2] = make_level(3500, 3800, 4600, 0);
      cfg_words[3] = make_level(3800, 4100, 4700, 15);
      cfg_words[4] = make_level(4100, 5000, 4800, 15);
      band_cut = '{1000, 3000, 3500, 3800, 4100, 5000};
      apply_config(1'b1, 1'b0);
      sample(3200, 0, CLS_STANDARD);
      sample(2995, 0, CLS_STANDARD);     // fell just under the band top: hold
      sample(2000, 0, CLS_STANDARD);
      sample(3999, 0, CLS_STANDARD);
      sample(4500, 0, CLS_STANDARD);
      sample(4099, 0, CLS_STANDARD);     // hold again one level down
      sample(3799, 0, CLS_STANDARD);     // two levels away: take
      item = '{kind: KIND_RESTART, battery_mv: '1, bus_mv: '1, chg_class: CLS_HOST};
      send_item(item);
      sample(2999, 0, CLS_STANDARD);     // first pass after restart: take
      sample(500, 0, CLS_STANDARD);      // no band
      sample(0, 0, CLS_STANDARD);
      sample(32767, 16383, CLS_STANDARD);
      sample(3100, 0, CLS_UNUSED);
      sample(3100, 0, CLS_HOST);
      sample(3100, 6500, CLS_FAST);
      sample(3100, 6499, CLS_FAST);
      sample(3100, 16383, CLS_FAST);
      sample(0, 0, CLS_FAST);
      sample(32767, 16383, CLS_UNUSED);

      for (int blk = 0; blk < BLOCKS; blk++) begin
         case (blk / 2)
            0: begin tx_idle_pct = 17; rx_idle_pct = 69; end
            1: begin tx_idle_pct = 69; rx_idle_pct = 17; end
            default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
         endcase
         case (blk)
            0: begin make_band_table(); apply_config(1'b1, 1'b0); end
            1: begin make_band_table(); apply_config(1'b1, 1'b1); end
            2: begin make_band_table(); apply_config(1'b0, 1'b1); end
            3: begin
               for (int i = 0; i < LEVELS; i++)
                  cfg_words[i] = WORD_W'({$urandom(), $urandom()});
               apply_config(1'b1, 1'b0);
            end
            4: begin
               for (int i = 0; i < LEVELS; i++) cfg_words[i] = '1;
               apply_config(1'b1, 1'b1);
            end
            default: begin make_band_table(); apply_config(1'b1, 1'b0); end
         endcase
         for (int n = 0; n < ITEMS_PER_BLOCK; n++) begin
            if (n == ITEMS_PER_BLOCK / 2) drain();
            send_random_item();
         end
      end

      drain();
      sb.finish_check();
      $display("covered %0d samples and %0d restarts across %0d register settings",
               sb.samples, sb.restarts, cfg_count);
      $display("%0d answers came from a band, %0d of them held by hysteresis",
               sb.table_hits, sb.held_values);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+rtl
rtl/idpm_vbs_pkg.sv
rtl/idpm_vbs_ifs.sv
rtl/idpm_vbs_core.sv
rtl/input_dpm_voltage_band_selector_top.sv
rtl/idpm_vbs_checker.sv
tb/tb_top.sv
